@@ rtl/core/tlpq_pkg.sv @@
`default_nettype none

package tlpq_pkg;

    // Default depth of each priority level.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LEVELS          = 3;

    // Request opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Priority request codes; every other code maps to the bottom level.
    localparam logic [1:0] PRIO_TOP = 2'd1;
    localparam logic [1:0] PRIO_MID = 2'd2;

    // Internal level indexes.
    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_BOT = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Served level reported when nothing was inserted or removed.
    localparam logic [1:0] SERVED_NONE = 2'd0;

    // Decision for one request, from the level control to the pipeline.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [1:0] status;
        logic [1:0] served;
    } t_decision;

endpackage

`default_nettype wire

@@ rtl/core/three_level_priority_queue.sv @@
// Stages: decision and store read in stage one, then the output register.
// Throughput: one request per cycle, insert or remove, unless the output stalls;
// set by the single-port byte store; its read data is registered before stage two.
// Reset: synchronous active-low reset empties all three levels at once;
// the byte store itself is not cleared and needs no clearing pass.
`default_nettype none

module three_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_op,
    input  wire logic [7:0] i_item_byte,
    input  wire logic [1:0] i_priority_req,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_result_byte,
    output logic      [1:0] o_status,
    output logic      [1:0] o_served_level
);

    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

    t_decision         dec;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        rd_data;
    logic              fire;
    logic              s1_adv;

    logic       r_s1_valid;
    logic       r_s1_rd;
    logic [1:0] r_s1_status;
    logic [1:0] r_s1_level;

    logic       r_s2_valid;
    logic [7:0] r_s2_byte;
    logic [1:0] r_s2_status;
    logic [1:0] r_s2_level;

    // Handshake: stage one moves on when the output stage is free or drains.
    assign s1_adv     = r_s1_valid && (!r_s2_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign fire       = i_in_valid && o_in_ready;

    tlpq_level_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (i_op),
        .i_priority_req (i_priority_req),
        .o_dec          (dec),
        .o_addr         (addr)
    );

    tlpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (fire && dec.wr_en),
        .i_rd_en   (fire && dec.rd_en),
        .i_addr    (addr),
        .i_wr_data (i_item_byte),
        .o_rd_data (rd_data)
    );

    // Stage one: request decision, alongside the store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_rd     <= dec.rd_en;
            r_s1_status <= dec.status;
            r_s1_level  <= dec.served;
        end
    end

    // Stage two: output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_byte   <= r_s1_rd ? rd_data : 8'd0;
            r_s2_status <= r_s1_status;
            r_s2_level  <= r_s1_level;
        end
    end

    assign o_out_valid    = r_s2_valid;
    assign o_result_byte  = r_s2_byte;
    assign o_status       = r_s2_status;
    assign o_served_level = r_s2_level;

endmodule

`default_nettype wire

@@ rtl/core/tlpq_store.sv @@
`default_nettype none

module tlpq_store
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [7:0]        i_wr_data,
    output logic      [7:0]        o_rd_data
);

    localparam int ENTRIES = LEVELS * QUEUE_DEPTH;

    logic [7:0] r_mem [ENTRIES];
    logic [7:0] r_rd_data;

    // Single write port; contents are undefined until written.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/tlpq_level_ctrl.sv @@
`default_nettype none

module tlpq_level_ctrl
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(LEVELS * QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_op,
    input  wire logic [1:0]        i_priority_req,
    output t_decision              o_dec,
    output logic      [ADDR_W-1:0] o_addr
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0] r_rd_ptr [LEVELS];
    logic [PTR_W-1:0] r_wr_ptr [LEVELS];
    logic [OCC_W-1:0] r_occ    [LEVELS];

    logic [1:0]       ins_lvl;
    logic [1:0]       rem_lvl;
    logic [1:0]       lvl;
    logic             any_full_lvl;
    logic             any_data;
    logic [OCC_W-1:0] ins_occ;
    logic [PTR_W-1:0] ptr;
    logic [PTR_W-1:0] ptr_next;
    logic [ADDR_W-1:0] base;
    logic             do_wr;
    logic             do_rd;

    // Map the priority code to a level; unknown codes go to the bottom.
    always_comb begin
        case (i_priority_req)
            PRIO_TOP: ins_lvl = LVL_TOP;
            PRIO_MID: ins_lvl = LVL_MID;
            default:  ins_lvl = LVL_BOT;
        endcase
    end

    // Pick the highest-priority level that holds data.
    always_comb begin
        any_data = 1'b1;
        if (r_occ[0] != '0) begin
            rem_lvl = LVL_TOP;
        end else if (r_occ[1] != '0) begin
            rem_lvl = LVL_MID;
        end else begin
            rem_lvl = LVL_BOT;
            any_data = (r_occ[2] != '0);
        end
    end

    // Occupancy of the level an insert targets.
    always_comb begin
        case (ins_lvl)
            LVL_TOP: ins_occ = r_occ[0];
            LVL_MID: ins_occ = r_occ[1];
            default: ins_occ = r_occ[2];
        endcase
    end

    assign any_full_lvl = (ins_occ == OCC_W'(QUEUE_DEPTH));
    assign lvl          = (i_op == OP_INSERT) ? ins_lvl : rem_lvl;
    assign do_wr        = (i_op == OP_INSERT) && !any_full_lvl;
    assign do_rd        = (i_op == OP_REMOVE) && any_data;

    // Select the pointer and the level base address.
    always_comb begin
        case (lvl)
            LVL_TOP: begin
                ptr  = (i_op == OP_INSERT) ? r_wr_ptr[0] : r_rd_ptr[0];
                base = '0;
            end
            LVL_MID: begin
                ptr  = (i_op == OP_INSERT) ? r_wr_ptr[1] : r_rd_ptr[1];
                base = ADDR_W'(QUEUE_DEPTH);
            end
            default: begin
                ptr  = (i_op == OP_INSERT) ? r_wr_ptr[2] : r_rd_ptr[2];
                base = ADDR_W'(2 * QUEUE_DEPTH);
            end
        endcase
    end

    assign ptr_next = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    assign o_addr   = base + ADDR_W'(ptr);

    // Decision handed to the pipeline.
    always_comb begin
        o_dec.wr_en  = do_wr;
        o_dec.rd_en  = do_rd;
        o_dec.served = (do_wr || do_rd) ? lvl + 2'd1 : SERVED_NONE;
        if (i_op == OP_INSERT) begin
            o_dec.status = any_full_lvl ? ST_FULL : ST_OK;
        end else begin
            o_dec.status = any_data ? ST_OK : ST_EMPTY;
        end
    end

    // Pointer and occupancy update for the accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_rd_ptr[i] <= '0;
                r_wr_ptr[i] <= '0;
                r_occ[i]    <= '0;
            end
        end else if (i_fire) begin
            for (int i = 0; i < LEVELS; i++) begin
                if (lvl == 2'(i)) begin
                    if (do_wr) begin
                        r_wr_ptr[i] <= ptr_next;
                        r_occ[i]    <= r_occ[i] + 1'b1;
                    end
                    if (do_rd) begin
                        r_rd_ptr[i] <= ptr_next;
                        r_occ[i]    <= r_occ[i] - 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/three_level_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module three_level_priority_queue_tb;
    import tlpq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS  = 265;

    // One request as it is presented at the input ports.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic [1:0] prio;
    } t_queue_req;

    // One result as it leaves the output ports.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic [1:0] level;
    } t_queue_resp;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       i_op           = OP_INSERT;
    logic [7:0] i_item_byte    = 8'h00;
    logic [1:0] i_priority_req = 2'd0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_result_byte;
    logic [1:0] o_status;
    logic [1:0] o_served_level;

    t_queue_req  pending_reqs[$];
    t_queue_resp expected_results[$];

    // Shadow copy of the three levels.
    logic [7:0] level_store [LEVELS][DEPTH];
    int         lvl_head  [LEVELS] = '{default: 0};
    int         lvl_tail  [LEVELS] = '{default: 0};
    int         lvl_count [LEVELS] = '{default: 0};

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_taken      = 1'b0;
    int  mismatch_count = 0;

    three_level_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_item_byte    (i_item_byte),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_byte  (o_result_byte),
        .o_status       (o_status),
        .o_served_level (o_served_level)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Apply one accepted request to the shadow levels and queue its result.
    task automatic serve_request(input t_queue_req req);
        t_queue_resp resp;
        logic [1:0]  lvl;
        bit          found;
        resp  = '0;
        found = 1'b0;
        lvl   = LVL_BOT;
        if (req.op == OP_INSERT) begin
            lvl = (req.prio == PRIO_TOP) ? LVL_TOP :
                  (req.prio == PRIO_MID) ? LVL_MID : LVL_BOT;
            if (lvl_count[lvl] >= DEPTH) begin
                resp.status = ST_FULL;
                resp.level  = SERVED_NONE;
            end else begin
                level_store[lvl][lvl_tail[lvl]] = req.data;
                lvl_tail[lvl]  = (lvl_tail[lvl] + 1 >= DEPTH) ? 0 : lvl_tail[lvl] + 1;
                lvl_count[lvl] = lvl_count[lvl] + 1;
                resp.status = ST_OK;
                resp.level  = lvl + 2'd1;
            end
        end else begin
            // Strict priority: the first non-empty level from the top wins.
            foreach (lvl_count[k]) begin
                if (!found && lvl_count[k] != 0) begin
                    found = 1'b1;
                    lvl   = 2'(k);
                end
            end
            if (!found) begin
                resp.status = ST_EMPTY;
                resp.level  = SERVED_NONE;
            end else begin
                resp.data      = level_store[lvl][lvl_head[lvl]];
                lvl_head[lvl]  = (lvl_head[lvl] + 1 >= DEPTH) ? 0 : lvl_head[lvl] + 1;
                lvl_count[lvl] = lvl_count[lvl] - 1;
                resp.status = ST_OK;
                resp.level  = lvl + 2'd1;
            end
        end
        expected_results.push_back(resp);
    endtask

    function automatic void add_request(input logic op, input logic [7:0] data,
                                        input logic [1:0] prio);
        t_queue_req req;
        req.op   = op;
        req.data = data;
        req.prio = prio;
        pending_reqs.push_back(req);
    endfunction

    // Queue one stretch of traffic and return how many requests it holds.
    // Fill bursts push one level toward and past full, drain bursts empty
    // the levels, and mixed stretches interleave both.
    function automatic int add_traffic_segment(input int kind);
        int         len;
        logic [1:0] prio;
        len  = 0;
        prio = 2'($urandom_range(3));
        case (kind)
            0, 1, 2: begin
                len = $urandom_range(DEPTH + 4, 4);
                for (int n = 0; n < len; n++) begin
                    add_request(OP_INSERT, 8'($urandom_range(255)), prio);
                end
            end
            3, 4: begin
                len = $urandom_range(2 * DEPTH, 4);
                for (int n = 0; n < len; n++) begin
                    add_request(OP_REMOVE, 8'($urandom_range(255)), 2'($urandom_range(3)));
                end
            end
            default: begin
                len = $urandom_range(12, 1);
                for (int n = 0; n < len; n++) begin
                    add_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                                2'($urandom_range(3)));
                end
            end
        endcase
        return len;
    endfunction

    function automatic void add_random_traffic(input int count);
        int added;
        added = 0;
        while (added < count) begin
            added += add_traffic_segment($urandom_range(9));
        end
    endfunction

    // Hold until every queued request is accepted and every result is back.
    task automatic wait_until_drained();
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic report_result(input string reason, input t_queue_resp want,
                                 input t_queue_resp got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: expected byte=%02h status=%0d level=%0d,",
                     $time, reason, want.data, want.status, want.level,
                     " got byte=%02h status=%0d level=%0d",
                     got.data, got.status, got.level);
        end
    endtask

    // Request driver: presents the next pending request, with random gaps.
    always @(negedge i_clk) begin : drive_requests
        t_queue_req next_req;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req       = pending_reqs.pop_front();
                i_in_valid     <= 1'b1;
                i_op           <= next_req.op;
                i_item_byte    <= next_req.data;
                i_priority_req <= next_req.prio;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at random.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge i_clk) begin : watch_ports
        t_queue_req  req;
        t_queue_resp got;
        t_queue_resp want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                req.op   = i_op;
                req.data = i_item_byte;
                req.prio = i_priority_req;
                serve_request(req);
            end
            if (o_out_valid && i_out_ready) begin
                got = {o_result_byte, o_status, o_served_level};
                if (expected_results.size() == 0) begin
                    report_result("result with nothing pending", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.data !== want.data || got.status !== want.status ||
                            got.level !== want.level) begin
                        report_result("result mismatch", want, got);
                    end
                end
            end
        end
    end

    // Stimulus and phase sequencing.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 15;
        recv_idle_pct = 86;

        // Directed: empty remove, each priority code including zero, byte
        // extremes, strict ordering across levels, and ignored remove fields.
        add_request(OP_REMOVE, 8'hFF, 2'd3);
        add_request(OP_INSERT, 8'h00, 2'd3);
        add_request(OP_INSERT, 8'hFF, PRIO_TOP);
        add_request(OP_INSERT, 8'hA5, PRIO_MID);
        add_request(OP_INSERT, 8'h5A, 2'd0);
        add_request(OP_REMOVE, 8'h00, 2'd0);
        add_request(OP_REMOVE, 8'hFF, PRIO_TOP);
        add_request(OP_REMOVE, 8'h3C, PRIO_MID);
        add_request(OP_REMOVE, 8'hC3, 2'd3);
        add_request(OP_REMOVE, 8'h00, 2'd0);
        add_request(OP_INSERT, 8'h80, 2'd3);
        add_request(OP_INSERT, 8'h01, PRIO_TOP);
        add_request(OP_REMOVE, 8'h00, 2'd0);
        add_request(OP_REMOVE, 8'h00, 2'd0);
        add_request(OP_REMOVE, 8'h00, 2'd0);

        // Insert more items than one level holds, at random priority codes.
        for (int n = 0; n < DEPTH + 3; n++) begin
            add_request(OP_INSERT, 8'($urandom_range(255)), 2'($urandom_range(3)) | 2'd0);
        end
        void'(add_traffic_segment(3));
        add_random_traffic(PHASE_ITEMS);
        wait_until_drained();

        // Sender mostly idle, receiver mostly ready.
        @(posedge i_clk);
        send_idle_pct = 86;
        recv_idle_pct = 15;
        add_random_traffic(PHASE_ITEMS);
        wait_until_drained();

        // Full rate on both sides.
        @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_traffic(PHASE_ITEMS);
        wait_until_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("three_level_priority_queue verification clean");
        end else begin
            $display("three_level_priority_queue verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(5_000_000);
        $display("three_level_priority_queue verification failed");
        $finish;
    end

endmodule
